[sv/sfsq_pkg.sv]
// Shared types and constants for the segregated free-slot queues.
// No dependencies; imported by every module of the block but sfsq_ram.
package sfsq_pkg;

   // Default sizing, handed down through top-level parameters
   localparam int SLOTS_PER_CLASS_DEF = 64;
   localparam int CLASS_COUNT_DEF     = 4;

   // Field widths
   localparam int TRACK_W   = 32;
   localparam int DOMAIN_W  = 16;
   localparam int CLASS_W   = 2;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 56;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TAKE = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_NEAR = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

   // Reset value of the take-near class register
   localparam logic [CLASS_W-1:0] NEAR_CLASS_RST = 2'd1;

   // One stored slot
   typedef struct packed {
      logic [TRACK_W-1:0]  track;
      logic [DOMAIN_W-1:0] domain;
   } slot_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_SHIFT,
      S_RESP
   } state_type;

endpackage

[sv/sfsq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfsq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[sv/sfsq_near_cmp.sv]
// Shared compare unit: match when the stored domain is within one of the key, or when forced.
// Depends on sfsq_pkg.
module sfsq_near_cmp (
   input  logic [sfsq_pkg::DOMAIN_W-1:0] slot_domain,
   input  logic [sfsq_pkg::DOMAIN_W-1:0] key_domain,
   input  logic                          force_hit,
   output logic                          hit
);
   import sfsq_pkg::*;

   logic [DOMAIN_W:0] slot_ext;
   logic [DOMAIN_W:0] key_ext;

   // widened by one bit so the +1 never wraps
   assign slot_ext = {1'b0, slot_domain};
   assign key_ext  = {1'b0, key_domain};

   assign hit = force_hit
             || (slot_ext == key_ext)
             || (slot_ext == key_ext + (DOMAIN_W+1)'(1))
             || (key_ext == slot_ext + (DOMAIN_W+1)'(1));

endmodule

[sv/segregated_free_slot_queues.sv]
// Top level: sequencer, class counters and slot RAM of the free-slot queues.
// Depends on sfsq_pkg, sfsq_ram and sfsq_near_cmp.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+------------------------------------------
//   req     | in  | tvalid/tready     | tuser command, tdata class/track/domains
//   rsp     | out | tvalid/tready     | tdata found/track/domain/status
//   csr     | in  | we (no wait)      | wdata near_search_class
//
// Push, an empty class and unknown commands go from execute straight to the
// result. Pop and take-near scan the class from the head to a match, then
// shift the later entries up, or go to the result when nothing matches. The
// single RAM port reads each entry once, to be compared ahead of the
// match or to move up toward the head behind it.
// Reset (synchronous) empties all classes and sets near_search_class to 1.
// A new beat is taken once the sequencer is idle, even while a result waits
// on rsp; a stalled rsp holds the next result in the final state.
module segregated_free_slot_queues #(
   parameter int SLOTS_PER_CLASS = sfsq_pkg::SLOTS_PER_CLASS_DEF,
   parameter int CLASS_COUNT     = sfsq_pkg::CLASS_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: size_class[1:0], slot_track[33:2], slot_domain[49:34],
   //        near_domain[65:50], zero fill [71:66]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sfsq_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: command[1:0]
   input  logic [sfsq_pkg::CMD_W-1:0]      req_tuser,
   // tdata: found[0], out_track[32:1], out_domain[48:33], status[50:49],
   //        zero fill [55:51]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sfsq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [sfsq_pkg::CLASS_W-1:0]    csr_wdata
);
   import sfsq_pkg::*;

   localparam int IW    = $clog2(SLOTS_PER_CLASS);
   localparam int NW    = $clog2(SLOTS_PER_CLASS + 1);
   localparam int DEPTH = CLASS_COUNT * SLOTS_PER_CLASS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CIW   = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
   localparam int SW    = $bits(slot_type);

   // control registers
   state_type            state_ff, state_in;
   logic [CLASS_W-1:0]   near_cls_ff;
   logic [NW-1:0]        cnt_ff [CLASS_COUNT];
   logic                 pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [CLASS_W-1:0]   cls_ff, cls_in;
   logic [TRACK_W-1:0]   trk_ff, trk_in;
   logic [DOMAIN_W-1:0]  dom_ff, dom_in;
   logic [DOMAIN_W-1:0]  nd_ff, nd_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [NW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [IW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [IW-1:0]        wr_idx_ff, wr_idx_in;
   logic                 res_found_ff, res_found_in;
   slot_type             res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0]  res_st_ff, res_st_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic                 req_beat;
   logic                 cls_ok;
   logic [CIW-1:0]       cidx;
   logic [NW-1:0]        cur_cnt;
   logic                 cnt_we;
   logic [NW-1:0]        cnt_wval;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   slot_type             ram_wdata;
   logic [AW-1:0]        ram_raddr;
   slot_type             ram_rdata;
   logic [SW-1:0]        ram_rbits;
   logic                 hit;
   logic                 more_rd;
   logic                 last_cmp;
   logic                 rsp_load;

   assign req_beat = req_tvalid && req_tready;
   assign cls_ok   = 32'(cls_ff) < CLASS_COUNT;
   assign cidx     = CIW'(cls_ff);
   assign cur_cnt  = cls_ok ? cnt_ff[cidx] : '0;
   assign more_rd  = rd_ptr_ff < n_ff;
   assign last_cmp = (NW'(cmp_idx_ff) + NW'(1)) == n_ff;
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);
   assign ram_rdata = slot_type'(ram_rbits);

   // slot RAM, one region of SLOTS_PER_CLASS entries per class
   sfsq_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (SW'(ram_wdata)),
      .rd_addr (ram_raddr),
      .rd_data (ram_rbits)
   );

   // shared compare; pop takes the head without looking
   sfsq_near_cmp u_cmp (
      .slot_domain (ram_rdata.domain),
      .key_domain  (nd_ff),
      .force_hit   (cmd_ff == CMD_POP),
      .hit         (hit)
   );

   // read address always follows the read pointer
   assign ram_raddr = AW'(cidx) * AW'(SLOTS_PER_CLASS) + AW'(rd_ptr_ff[IW-1:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) state_in = S_EXEC;
         end
         S_EXEC: begin
            if ((cmd_ff == CMD_POP || cmd_ff == CMD_TAKE) && cls_ok && cur_cnt != '0) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            if (pend_ff && hit) begin
               state_in = S_SHIFT;
            end else if (pend_ff && last_cmp) begin
               state_in = S_RESP;
            end
         end
         S_SHIFT: begin
            if (!more_rd) state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      req_tready   = (state_ff == S_IDLE);
      cmd_in       = cmd_ff;
      cls_in       = cls_ff;
      trk_in       = trk_ff;
      dom_in       = dom_ff;
      nd_in        = nd_ff;
      n_in         = n_ff;
      rd_ptr_in    = rd_ptr_ff;
      cmp_idx_in   = cmp_idx_ff;
      wr_idx_in    = wr_idx_ff;
      pend_in      = pend_ff;
      res_found_in = res_found_ff;
      res_slot_in  = res_slot_ff;
      res_st_in    = res_st_ff;
      cnt_we       = 1'b0;
      cnt_wval     = cur_cnt;
      ram_we       = 1'b0;
      ram_waddr    = AW'(cidx) * AW'(SLOTS_PER_CLASS) + AW'(cur_cnt[IW-1:0]);
      ram_wdata    = '{track: trk_ff, domain: dom_ff};
      case (state_ff)
         S_IDLE: begin
            // latch the beat; take-near works on the configured class
            if (req_beat) begin
               cmd_in = req_tuser;
               cls_in = (req_tuser == CMD_TAKE) ? near_cls_ff : req_tdata[1:0];
               trk_in = req_tdata[33:2];
               dom_in = req_tdata[49:34];
               nd_in  = req_tdata[65:50];
            end
         end
         S_EXEC: begin
            res_found_in = 1'b0;
            res_slot_in  = '0;
            res_st_in    = ST_OK;
            rd_ptr_in    = '0;
            pend_in      = 1'b0;
            n_in         = cur_cnt;
            case (cmd_ff)
               CMD_PUSH: begin
                  if (!cls_ok || 32'(cur_cnt) >= SLOTS_PER_CLASS) begin
                     res_st_in = ST_FULL;
                  end else begin
                     ram_we   = 1'b1;
                     cnt_we   = 1'b1;
                     cnt_wval = cur_cnt + NW'(1);
                  end
               end
               CMD_POP, CMD_TAKE: begin
                  if (!cls_ok || cur_cnt == '0) res_st_in = ST_EMPTY;
               end
               default: res_st_in = ST_OK;
            endcase
         end
         S_SCAN: begin
            if (pend_ff && hit) begin
               // match: report it, then close the gap behind it
               res_found_in = 1'b1;
               res_slot_in  = ram_rdata;
               res_st_in    = ST_OK;
               wr_idx_in    = cmp_idx_ff;
               rd_ptr_in    = NW'(cmp_idx_ff) + NW'(1);
               pend_in      = 1'b0;
            end else if (pend_ff && last_cmp) begin
               res_st_in = ST_NO_NEAR;
               pend_in   = 1'b0;
            end else if (more_rd) begin
               pend_in    = 1'b1;
               cmp_idx_in = rd_ptr_ff[IW-1:0];
               rd_ptr_in  = rd_ptr_ff + NW'(1);
            end else begin
               pend_in = 1'b0;
            end
         end
         S_SHIFT: begin
            // move each later entry up one place
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = AW'(cidx) * AW'(SLOTS_PER_CLASS) + AW'(wr_idx_ff);
               ram_wdata = ram_rdata;
               wr_idx_in = wr_idx_ff + IW'(1);
            end
            if (more_rd) begin
               pend_in   = 1'b1;
               rd_ptr_in = rd_ptr_ff + NW'(1);
            end else begin
               pend_in  = 1'b0;
               cnt_we   = 1'b1;
               cnt_wval = n_ff - NW'(1);
            end
         end
         S_RESP: begin
            pend_in = 1'b0;
         end
         default: pend_in = 1'b0;
      endcase
   end

   // result output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({res_st_ff, res_slot_ff.domain,
                                     res_slot_ff.track, res_found_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         near_cls_ff  <= NEAR_CLASS_RST;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CLASS_COUNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) near_cls_ff <= csr_wdata;
         if (cnt_we && cls_ok) cnt_ff[cidx] <= cnt_wval;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cls_ff       <= cls_in;
      trk_ff       <= trk_in;
      dom_ff       <= dom_in;
      nd_ff        <= nd_in;
      n_ff         <= n_in;
      rd_ptr_ff    <= rd_ptr_in;
      cmp_idx_ff   <= cmp_idx_in;
      wr_idx_ff    <= wr_idx_in;
      res_found_ff <= res_found_in;
      res_slot_ff  <= res_slot_in;
      res_st_ff    <= res_st_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

[bench/sfsq_checker.sv]
`timescale 1ns / 1ps
// Checker for the segregated free-slot queues: watches req, csr and rsp,
// keeps its own copy of the class queues and compares every rsp beat.
// Depends on sfsq_pkg.
module sfsq_checker #(
   parameter int SLOTS_PER_CLASS = sfsq_pkg::SLOTS_PER_CLASS_DEF,
   parameter int CLASS_COUNT     = sfsq_pkg::CLASS_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [sfsq_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [sfsq_pkg::CMD_W-1:0]      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [sfsq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [sfsq_pkg::CLASS_W-1:0]    csr_wdata,
   output int                              mismatch_count,
   output int                              answers_due
);
   import sfsq_pkg::*;

   // rsp tdata layout, highest bit first
   typedef struct packed {
      logic [4:0]          fill;
      logic [STATUS_W-1:0] status;
      logic [DOMAIN_W-1:0] domain;
      logic [TRACK_W-1:0]  track;
      logic                found;
   } slot_answer_type;

   // predictor copy of the queues and the take-near class
   slot_type           free_slots [CLASS_COUNT][SLOTS_PER_CLASS];
   int unsigned        held [CLASS_COUNT];
   logic [CLASS_W-1:0] near_class;

   slot_answer_type answers_awaited [$];
   slot_answer_type got_answer;
   slot_answer_type want_answer;

   // remove entry pos of class c, close the gap toward the head
   function automatic slot_answer_type take_slot_at(int unsigned c, int unsigned pos);
      slot_answer_type ans;
      ans = '0;
      ans.found  = 1'b1;
      ans.track  = free_slots[c][pos].track;
      ans.domain = free_slots[c][pos].domain;
      ans.status = ST_OK;
      for (int unsigned i = pos; i + 1 < held[c]; i++)
         free_slots[c][i] = free_slots[c][i + 1];
      held[c]--;
      return ans;
   endfunction

   // apply one req beat to the queue copy and return the answer it earns
   function automatic slot_answer_type predict_slot_op(logic [CMD_W-1:0] cmd,
                                                       logic [CLASS_W-1:0] cls,
                                                       logic [TRACK_W-1:0] trk,
                                                       logic [DOMAIN_W-1:0] dom,
                                                       logic [DOMAIN_W-1:0] nd);
      slot_answer_type ans;
      int unsigned     c;
      int unsigned     pos;
      int unsigned     spread;
      bit              hit;
      ans = '0;
      c   = cls;
      hit = 1'b0;
      pos = 0;
      case (cmd)
         CMD_PUSH: begin
            if (c >= CLASS_COUNT || held[c] >= SLOTS_PER_CLASS) begin
               ans.status = ST_FULL;
            end else begin
               free_slots[c][held[c]] = {trk, dom};
               held[c]++;
            end
         end
         CMD_POP: begin
            if (c >= CLASS_COUNT || held[c] == 0) ans.status = ST_EMPTY;
            else ans = take_slot_at(c, 0);
         end
         CMD_TAKE: begin
            c = near_class;
            if (c >= CLASS_COUNT || held[c] == 0) begin
               ans.status = ST_EMPTY;
            end else begin
               // first slot from the head within one domain step
               while (!hit && pos < held[c]) begin
                  spread = (free_slots[c][pos].domain > nd) ?
                           free_slots[c][pos].domain - nd : nd - free_slots[c][pos].domain;
                  if (spread <= 1) hit = 1'b1;
                  else pos++;
               end
               if (hit) ans = take_slot_at(c, pos);
               else ans.status = ST_NO_NEAR;
            end
         end
         default: ;  // unused code: no change, all zero
      endcase
      return ans;
   endfunction

   task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   // sample both channels and the csr on every rising edge
   always @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CLASS_COUNT; c++) held[c] = 0;
         near_class = NEAR_CLASS_RST;
         answers_awaited.delete();
      end else begin
         // result beat against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got_answer = rsp_tdata;
            if (answers_awaited.size() == 0) begin
               $error("rsp beat %h with no result expected", rsp_tdata);
               mismatch_count++;
            end else begin
               want_answer = answers_awaited.pop_front();
               check_field("found", 32'(want_answer.found), 32'(got_answer.found));
               check_field("out_track", want_answer.track, got_answer.track);
               check_field("out_domain", 32'(want_answer.domain), 32'(got_answer.domain));
               check_field("status", 32'(want_answer.status), 32'(got_answer.status));
               check_field("zero fill", 32'(want_answer.fill), 32'(got_answer.fill));
            end
         end
         if (csr_we) near_class = csr_wdata;
         // request beat: predict its answer
         if (req_tvalid && req_tready)
            answers_awaited.push_back(predict_slot_op(req_tuser, req_tdata[1:0],
                                                      req_tdata[33:2], req_tdata[49:34],
                                                      req_tdata[65:50]));
      end
      answers_due = answers_awaited.size();
   end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Top of the bench for segregated_free_slot_queues: clock, reset, req and csr
// stimulus, rsp back-pressure and the verdict. Depends on sfsq_pkg, sfsq_checker.
module testbench;
   import sfsq_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CLASS_W-1:0]    csr_wdata = '0;

   int mismatch_count;
   int answers_due;
   int gap_pct = 18;
   int stall_pct = 18;

   segregated_free_slot_queues u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   sfsq_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .answers_due    (answers_due)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // rsp back-pressure, redrawn every cycle
   initial begin
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= stall_pct);
      end
   end

   // hard stop
   initial begin
      #15_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   // one req beat, with random idle cycles ahead of it
   task automatic send_req(logic [CMD_W-1:0] cmd, logic [CLASS_W-1:0] cls,
                           logic [TRACK_W-1:0] trk, logic [DOMAIN_W-1:0] dom,
                           logic [DOMAIN_W-1:0] nd);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {6'b0, nd, dom, trk, cls};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and wait for every outstanding answer
   task automatic drain_answers();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (answers_due != 0) @(negedge clock);
   endtask

   task automatic set_near_class(logic [CLASS_W-1:0] value);
      drain_answers();
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // random beats: command mix, class bias toward the take-near class,
   // domains mostly clustered around base so take-near finds matches
   task automatic run_phase(int items, int push_w, int pop_w, int take_w, int bias,
                            logic [CLASS_W-1:0] near_cls, logic [DOMAIN_W-1:0] base);
      int                  r;
      logic [CMD_W-1:0]    cmd;
      logic [CLASS_W-1:0]  cls;
      logic [DOMAIN_W-1:0] dom;
      logic [DOMAIN_W-1:0] nd;
      for (int k = 0; k < items; k++) begin
         r = $urandom_range(99);
         if (r < push_w) cmd = CMD_PUSH;
         else if (r < push_w + pop_w) cmd = CMD_POP;
         else if (r < push_w + pop_w + take_w) cmd = CMD_TAKE;
         else cmd = CMD_UNUSED;
         cls = ($urandom_range(99) < bias) ? near_cls : CLASS_W'($urandom_range(3));
         dom = ($urandom_range(99) < 75) ? base + DOMAIN_W'($urandom_range(7))
                                         : DOMAIN_W'($urandom);
         nd  = ($urandom_range(99) < 80) ? base + DOMAIN_W'($urandom_range(9)) - DOMAIN_W'(1)
                                         : DOMAIN_W'($urandom);
         send_req(cmd, cls, $urandom, dom, nd);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty cases with the reset take-near class
      send_req(CMD_POP,  2'd0, 32'h0, 16'h0, 16'h0);
      send_req(CMD_TAKE, 2'd0, 32'h0, 16'h0, 16'h0);
      // fill class 1 with extreme slots
      send_req(CMD_PUSH, 2'd1, 32'h0000_0000, 16'h0000, 16'h0);
      send_req(CMD_PUSH, 2'd1, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
      send_req(CMD_PUSH, 2'd1, 32'hA5A5_5A5A, 16'd100, 16'h0);
      send_req(CMD_PUSH, 2'd1, 32'h1234_5678, 16'd5, 16'h0);
      // no match, middle match, head match, match one above
      send_req(CMD_TAKE, 2'd0, 32'h0, 16'h0, 16'd50);
      send_req(CMD_TAKE, 2'd0, 32'h0, 16'h0, 16'd101);
      send_req(CMD_TAKE, 2'd0, 32'h0, 16'h0, 16'd1);
      send_req(CMD_TAKE, 2'd0, 32'h0, 16'h0, 16'hFFFE);
      send_req(CMD_POP,  2'd1, 32'h0, 16'h0, 16'h0);
      send_req(CMD_POP,  2'd1, 32'h0, 16'h0, 16'h0);
      // unused code with every field at its top
      send_req(CMD_UNUSED, 2'd3, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      // the other classes
      send_req(CMD_PUSH, 2'd0, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF);
      send_req(CMD_PUSH, 2'd2, 32'h0000_0000, 16'hFFFF, 16'h0000);
      send_req(CMD_PUSH, 2'd3, 32'h8000_0001, 16'h8000, 16'h7FFF);
      send_req(CMD_POP,  2'd0, 32'h0, 16'h0, 16'h0);
      send_req(CMD_POP,  2'd2, 32'h0, 16'h0, 16'h0);
      send_req(CMD_POP,  2'd3, 32'h0, 16'h0, 16'h0);
      send_req(CMD_TAKE, 2'd0, 32'h0, 16'h0, 16'hFFFF);

      // random phases, take-near class changed only while drained
      set_near_class(2'd0);
      run_phase(160, 50, 20, 28, 40, 2'd0, 16'h0000);
      set_near_class(2'd3);
      run_phase(170, 85, 5, 8, 75, 2'd3, 16'hFFF8);
      drain_answers();
      run_phase(60, 20, 20, 58, 50, 2'd3, 16'hFFF8);
      set_near_class(2'd2);
      run_phase(140, 40, 30, 28, 50, 2'd2, 16'($urandom));
      set_near_class(2'd1);
      run_phase(150, 15, 40, 43, 50, 2'd1, 16'($urandom));
      set_near_class(2'($urandom_range(3)));
      run_phase(100, 50, 20, 28, 40, 2'($urandom_range(3)), 16'($urandom));
      // stretch without any idling on either side
      set_near_class(2'd3);
      gap_pct   = 0;
      stall_pct = 0;
      run_phase(120, 45, 25, 28, 50, 2'd3, 16'($urandom));
      gap_pct   = 18;
      stall_pct = 18;

      drain_answers();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && answers_due == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
